[design/bsa_pkg.sv]
// ----------------------------------------------------------------------------
// Bit stack array package
// Shared sizes, request codes and status codes for the bit stack array.
// ----------------------------------------------------------------------------
package bsa_pkg;

	// Storage geometry.
	localparam int CAPACITY_BITS = 4096;
	localparam int WORD_BITS     = 64;
	localparam int WORD_COUNT    = (CAPACITY_BITS + WORD_BITS - 1) / WORD_BITS;
	localparam int SEL_W         = $clog2(WORD_BITS);
	localparam int ADDR_W        = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;

	// Field widths of the request and result items.
	localparam int POS_W = 12;
	localparam int LEN_W = 13;

	// Request operations.
	typedef enum logic [1:0] {
		OP_SET  = 2'd0,
		OP_GET  = 2'd1,
		OP_PUSH = 2'd2,
		OP_POP  = 2'd3
	} op_t;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

endpackage

[design/bsa_ram.sv]
// ----------------------------------------------------------------------------
// Bit stack array word memory
// Simple dual-port synchronous RAM: one write port, one registered read port.
// A read and a write to the same address in one cycle return the old word.
// ----------------------------------------------------------------------------
module bsa_ram #(
	parameter int DEPTH  = 64,
	parameter int WIDTH  = 64,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port; data holds while no read is issued.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[design/bit_stack_array_core.sv]
// ----------------------------------------------------------------------------
// Bit stack array core
// Fixed-capacity bit vector with a length: set, get, push and pop requests.
// ----------------------------------------------------------------------------
// Each request gives exactly one result. The core sustains one request per
// clock cycle while the output is not stalled. A result passes through the
// stage 1 registers and the output register before it is offered. That rate
// is set by the word memory, which does one read per request and a write
// back for each set or push that succeeds; a request that touches the word
// written by the request just ahead of it gets that word forwarded. The
// length is kept in a register and updated when a request is accepted, so
// status and length are decided at once. An output register holds a
// finished result while the next request is taken. No clearing pass is needed after reset.
module bit_stack_array_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [1:0] req_type, [13:2] bit_index, [14] bit_value, [15] zero
	input  logic [15:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [1:0] status, [2] read_bit, [15:3] length_now
	output logic [15:0] m_axis_tdata
);
	import bsa_pkg::*;

	// Request fields.
	op_t              req_op;
	logic [POS_W-1:0] req_idx;
	logic             req_val;

	assign req_op  = op_t'(s_axis_tdata[1:0]);
	assign req_idx = s_axis_tdata[13:2];
	assign req_val = s_axis_tdata[14];

	// Current length and decode at accept time.
	logic [LEN_W-1:0] count_q;
	logic [LEN_W-1:0] count_next;
	status_t          dec_status;
	logic [POS_W-1:0] dec_pos;
	logic             dec_wr;
	logic             dec_rd;

	logic accept;
	logic adv;

	// Stage 1 request registers.
	logic             v_s1;
	status_t          status_s1;
	logic [LEN_W-1:0] len_s1;
	logic [POS_W-1:0] pos_s1;
	logic             wr_s1;
	logic             rd_s1;
	logic             val_s1;
	logic             fwd_hit_s1;
	logic [WORD_BITS-1:0] fwd_word_s1;

	// Memory ports.
	logic                 ram_we;
	logic [ADDR_W-1:0]    ram_waddr;
	logic [WORD_BITS-1:0] ram_wdata;
	logic [ADDR_W-1:0]    ram_raddr;
	logic [WORD_BITS-1:0] ram_rdata;

	// Stage 1 word update.
	logic [WORD_BITS-1:0] cur_word;
	logic [WORD_BITS-1:0] new_word;
	logic [SEL_W-1:0]     sel_s1;
	logic                 rbit_s1;

	// Output register.
	logic             out_valid_q;
	status_t          out_status_q;
	logic             out_bit_q;
	logic [LEN_W-1:0] out_len_q;

	// Handshake: stage 1 moves on when the output register is free or drained.
	assign adv           = v_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !v_s1 || adv;
	assign accept        = s_axis_tvalid && s_axis_tready;

	// Decide status, new length and bit position from the current length.
	always_comb begin
		count_next = count_q;
		dec_status = ST_OK;
		dec_pos    = req_idx;
		dec_wr     = 1'b0;
		dec_rd     = 1'b0;
		unique case (req_op)
			OP_SET, OP_GET: begin
				if ({1'b0, req_idx} >= count_q) begin
					dec_status = ST_RANGE;
				end else begin
					dec_wr = (req_op == OP_SET);
					dec_rd = (req_op == OP_GET);
				end
			end
			OP_PUSH: begin
				dec_pos = count_q[POS_W-1:0];
				if (count_q >= LEN_W'(CAPACITY_BITS)) begin
					dec_status = ST_FULL;
				end else begin
					dec_wr     = 1'b1;
					count_next = count_q + LEN_W'(1);
				end
			end
			OP_POP: begin
				count_next = count_q - LEN_W'(1);
				dec_pos    = count_next[POS_W-1:0];
				if (count_q == '0) begin
					dec_status = ST_EMPTY;
					count_next = count_q;
				end else begin
					dec_rd = 1'b1;
				end
			end
			default: begin
				dec_status = ST_OK;
			end
		endcase
	end

	// Read the addressed word when a request is accepted.
	assign ram_raddr = dec_pos[POS_W-1:SEL_W];

	// Length register and stage 1 valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			v_s1    <= 1'b0;
		end else begin
			if (accept) begin
				count_q <= count_next;
			end
			if (accept) begin
				v_s1 <= 1'b1;
			end else if (adv) begin
				v_s1 <= 1'b0;
			end
		end
	end

	// Stage 1 payload, with a forward of a write to the same word this cycle.
	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1   <= dec_status;
			len_s1      <= count_next;
			pos_s1      <= dec_pos;
			wr_s1       <= dec_wr;
			rd_s1       <= dec_rd;
			val_s1      <= req_val;
			fwd_hit_s1  <= ram_we && (ram_waddr == ram_raddr);
			fwd_word_s1 <= ram_wdata;
		end
	end

	// Merge the bit into the word and pick the read bit.
	assign sel_s1   = pos_s1[SEL_W-1:0];
	assign cur_word = fwd_hit_s1 ? fwd_word_s1 : ram_rdata;

	always_comb begin
		new_word         = cur_word;
		new_word[sel_s1] = val_s1;
	end

	assign rbit_s1   = rd_s1 && cur_word[sel_s1];
	assign ram_we    = adv && wr_s1;
	assign ram_waddr = pos_s1[POS_W-1:SEL_W];
	assign ram_wdata = new_word;

	bsa_ram #(
		.DEPTH (WORD_COUNT),
		.WIDTH (WORD_BITS),
		.ADDR_W(ADDR_W)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (accept),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (adv) begin
			out_status_q <= status_s1;
			out_bit_q    <= rbit_s1;
			out_len_q    <= len_s1;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_len_q, out_bit_q, out_status_q};

	// The length never goes beyond the capacity.
	a_len_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= LEN_W'(CAPACITY_BITS))
		else $error("length beyond capacity");

	// The memory is written only when stage 1 hands its result on.
	a_wr_adv: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (v_s1 && adv))
		else $error("memory write without stage advance");

	// A push that is not full raises the length by one.
	a_push_inc: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req_op == OP_PUSH && count_q < LEN_W'(CAPACITY_BITS))
		|=> (count_q == $past(count_q) + LEN_W'(1)))
		else $error("push did not raise length");

	// A refused request never reports a read bit.
	a_err_bit: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_status_q != ST_OK) |-> !out_bit_q)
		else $error("read bit set on refused request");

endmodule

[dv/bit_stack_array_core_tb.sv]
// ----------------------------------------------------------------------------
// Bit stack array core testbench
// Drives set, get, push and pop requests through the request stream with
// random gaps and stalls on both sides. Expected results come from an
// in-bench model of the bit store and length, and each returned result is
// compared field by field in order.
// ----------------------------------------------------------------------------
module bit_stack_array_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bsa_pkg::*;

	// Bench constants.
	localparam int HALF_PERIOD     = 6;
	localparam int RESET_CYCLES    = 11;
	localparam int IDLE_PCT        = 10;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int SETTLE_CYCLES   = 10;
	localparam int MAX_PRINTED     = 100;

	// One expected result, fields at the block's widths.
	typedef struct packed {
		status_t          status;
		logic             read_bit;
		logic [LEN_W-1:0] length_now;
	} bit_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic [15:0] s_tdata = '0;
	logic        m_tready = 1'b0;
	logic        s_axis_tready;
	logic        m_axis_tvalid;
	logic [15:0] m_axis_tdata;

	// Bench copy of the store and its length.
	logic [WORD_BITS-1:0] model_words [WORD_COUNT];
	logic [LEN_W-1:0]     model_len = '0;

	bit_result_t pending_results[$];
	int          mismatch_count = 0;
	int          result_count = 0;
	bit          steady = 1'b0;
	int          hold_off_req = 0;

	bit_stack_array_core DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// Free-running clock.
	always #(HALF_PERIOD) clk = ~clk;

	// Apply one request to the bench copy of the store and return its result.
	function automatic bit_result_t apply_bit_request(op_t op, logic [POS_W-1:0] idx,
			logic val);
		bit_result_t r;
		int pos;
		r.status = ST_OK;
		r.read_bit = 1'b0;
		pos = int'(idx);
		case (op)
			OP_SET, OP_GET: begin
				if (pos >= model_len)
					r.status = ST_RANGE;
				else if (op == OP_SET)
					model_words[pos / WORD_BITS][pos % WORD_BITS] = val;
				else
					r.read_bit = model_words[pos / WORD_BITS][pos % WORD_BITS];
			end
			OP_PUSH: begin
				if (model_len >= CAPACITY_BITS) begin
					r.status = ST_FULL;
				end else begin
					pos = int'(model_len);
					model_words[pos / WORD_BITS][pos % WORD_BITS] = val;
					model_len = model_len + LEN_W'(1);
				end
			end
			default: begin
				if (model_len == 0) begin
					r.status = ST_EMPTY;
				end else begin
					model_len = model_len - LEN_W'(1);
					pos = int'(model_len);
					r.read_bit = model_words[pos / WORD_BITS][pos % WORD_BITS];
				end
			end
		endcase
		r.length_now = model_len;
		return r;
	endfunction

	// Count a mismatch and print one line about it while under the print limit.
	task automatic report_mismatch(input string what, input int got, input int want);
		mismatch_count++;
		if (mismatch_count <= MAX_PRINTED)
			$display("[%0t] result %0d: %s got %0d, expected %0d",
				$realtime, result_count, what, got, want);
	endtask

	// Offer one request, with a random gap ahead of it, and wait until it is taken.
	task automatic send_request(input op_t op, input logic [POS_W-1:0] idx, input logic val);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {1'b0, val, idx, op};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		pending_results.push_back(apply_bit_request(op, idx, val));
	endtask

	// Stop offering and wait until every expected result has come back.
	task automatic wait_results_drained;
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// One random request; indices mostly below the length, some at or past it.
	task automatic send_random_request(input int push_w, input int pop_w, input int far_pct);
		int roll;
		op_t op;
		logic [POS_W-1:0] idx;
		roll = $urandom_range(99);
		if (roll < push_w)
			op = OP_PUSH;
		else if (roll < push_w + pop_w)
			op = OP_POP;
		else if (roll < push_w + pop_w + (100 - push_w - pop_w) / 2)
			op = OP_SET;
		else
			op = OP_GET;
		if (model_len != 0 && $urandom_range(99) >= far_pct)
			idx = POS_W'($urandom_range(model_len - 1));
		else if ($urandom_range(1))
			idx = model_len[POS_W-1:0];
		else
			idx = POS_W'($urandom_range(CAPACITY_BITS - 1));
		send_request(op, idx, 1'($urandom_range(1)));
	endtask

	// Receiver: random stalls, a long hold-off on request, none while steady.
	always @(posedge clk) begin : receiver
		static int hold_left = 0;
		static int hold_seen = 0;
		if (hold_seen != hold_off_req) begin
			hold_seen = hold_off_req;
			hold_left = HOLD_OFF_CYCLES;
		end
		if (hold_left != 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (steady) begin
			m_tready <= 1'b1;
		end else begin
			m_tready <= ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// Compare each accepted result with the oldest expectation.
	always @(posedge clk) begin : result_checker
		bit_result_t want;
		if (arst_n && m_axis_tvalid && m_tready) begin
			result_count++;
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result, tdata", int'(m_axis_tdata), 0);
			end else begin
				want = pending_results.pop_front();
				if (m_axis_tdata[1:0] !== want.status)
					report_mismatch("status", int'(m_axis_tdata[1:0]),
						int'(want.status));
				if (m_axis_tdata[2] !== want.read_bit)
					report_mismatch("read_bit", int'(m_axis_tdata[2]),
						int'(want.read_bit));
				if (m_axis_tdata[15:3] !== want.length_now)
					report_mismatch("length_now", int'(m_axis_tdata[15:3]),
						int'(want.length_now));
			end
		end
	end

	// Edges of the empty store, a short stack and the bounds of the index.
	task automatic test_directed;
		send_request(OP_POP, 12'd0, 1'b0);
		send_request(OP_GET, 12'd0, 1'b0);
		send_request(OP_SET, 12'd4095, 1'b1);
		send_request(OP_PUSH, 12'd4095, 1'b1);
		send_request(OP_PUSH, 12'd0, 1'b0);
		send_request(OP_PUSH, 12'd0, 1'b1);
		send_request(OP_GET, 12'd0, 1'b0);
		send_request(OP_GET, 12'd1, 1'b1);
		send_request(OP_GET, 12'd2, 1'b0);
		send_request(OP_GET, 12'd3, 1'b0);
		send_request(OP_SET, 12'd3, 1'b1);
		send_request(OP_SET, 12'd1, 1'b1);
		send_request(OP_GET, 12'd1, 1'b0);
		send_request(OP_SET, 12'd0, 1'b0);
		send_request(OP_GET, 12'd0, 1'b1);
		send_request(OP_GET, 12'd4095, 1'b0);
		send_request(OP_POP, 12'd4095, 1'b1);
		send_request(OP_POP, 12'd0, 1'b0);
		send_request(OP_POP, 12'd0, 1'b0);
		send_request(OP_POP, 12'd0, 1'b0);
		send_request(OP_PUSH, 12'd0, 1'b0);
		send_request(OP_GET, 12'd0, 1'b1);
		send_request(OP_POP, 12'd0, 1'b0);
		wait_results_drained();
	endtask

	// Random mix at small lengths; the first stretch runs with no idling.
	task automatic test_random_mix;
		steady = 1'b1;
		repeat (300)
			send_random_request(28, 22, 15);
		steady = 1'b0;
		repeat (800)
			send_random_request(28, 22, 15);
		wait_results_drained();
	endtask

	// Fill to capacity, push when full, work near the top, then drain past empty.
	task automatic test_fill_and_drain;
		while (model_len < CAPACITY_BITS)
			send_request(OP_PUSH, POS_W'($urandom_range(CAPACITY_BITS - 1)),
				1'($urandom_range(1)));
		send_request(OP_PUSH, 12'd0, 1'b1);
		send_request(OP_PUSH, 12'd4095, 1'b0);
		send_request(OP_GET, 12'd4095, 1'b0);
		send_request(OP_SET, 12'd4095, ~model_words[WORD_COUNT - 1][WORD_BITS - 1]);
		send_request(OP_GET, 12'd4095, 1'b0);
		send_request(OP_GET, 12'd0, 1'b0);
		repeat (200)
			send_random_request(25, 25, 5);
		while (model_len != 0) begin
			if ($urandom_range(99) < 10)
				send_random_request(0, 0, 5);
			else
				send_request(OP_POP, POS_W'($urandom_range(CAPACITY_BITS - 1)),
					1'($urandom_range(1)));
		end
		send_request(OP_POP, 12'd0, 1'b0);
		wait_results_drained();
	endtask

	// Receiver holds off long enough that the core stalls its input.
	task automatic test_backpressure;
		hold_off_req++;
		repeat (60)
			send_random_request(40, 15, 10);
		wait_results_drained();
		repeat (40)
			send_random_request(30, 20, 10);
		wait_results_drained();
	endtask

	// Test sequence.
	initial begin
		repeat (RESET_CYCLES)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_mix();
		test_fill_and_drain();
		test_backpressure();
		repeat (SETTLE_CYCLES)
			@(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	// Watchdog on the whole run.
	initial begin
		#(4_000_000);
		$display("CHECK FAILED");
		$finish;
	end

endmodule

[bit_stack_array_core.f]
design/bsa_pkg.sv
design/bsa_ram.sv
design/bit_stack_array_core.sv
dv/bit_stack_array_core_tb.sv
